/* design/tsl_pkg.sv */
// Shared types and constants for the throttle slew limiter with DSHOT/PWM mapping.
// Used by the channel interfaces, the slew stage, the drive mapper and the top level.
// No dependencies.
package tsl_pkg;

    // Field widths
    localparam int LEVEL_W    = 18;
    localparam int DRIVE_W    = 16;
    localparam int MS_W       = 16;
    localparam int RATE_W     = 16;
    localparam int PULSE_W    = 16;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Scale and deadband in thousandths of a percent; elapsed-time limit in milliseconds
    localparam int FULL_SCALE    = 100000;
    localparam int DEADBAND      = 500;
    localparam int DSHOT_SPAN    = 99500;
    localparam int ELAPSED_LIMIT = 1000;

    // DSHOT codes
    localparam int DSHOT_LOW      = 48;
    localparam int DSHOT_HIGH     = 2047;
    localparam int DSHOT_REV_HIGH = 1047;
    localparam int DSHOT_FWD_LOW  = 1049;
    localparam int DSHOT_UNI_K    = DSHOT_HIGH - DSHOT_LOW;
    localparam int DSHOT_REV_K    = DSHOT_REV_HIGH - DSHOT_LOW;
    localparam int DSHOT_FWD_K    = DSHOT_HIGH - DSHOT_FWD_LOW;

    // Internal widths
    localparam int MAG_W     = 17;   // saturated magnitude, up to full scale
    localparam int STEP_MS_W = 10;   // elapsed time after the long-gap rule
    localparam int STEP_W    = RATE_W + STEP_MS_W;
    localparam int DIFF_W    = LEVEL_W + 1;
    localparam int PROD_W    = MAG_W + PULSE_W;
    localparam int NUM_W     = 28;   // numerator width fed to the reciprocal multiply
    localparam int RECIP_W   = 29;
    localparam int QPROD_W   = NUM_W + RECIP_W;

    // Exact division by reciprocal: for numerators below 2**NUM_W the product
    // with ceil(2**s / d), shifted right by s, equals the true quotient.
    localparam int PWM_PRE_SHIFT = 5;
    localparam int PWM_DIV       = FULL_SCALE >> PWM_PRE_SHIFT;
    localparam int DSHOT_SHIFT   = 45;
    localparam int PWM_SHIFT     = 40;
    localparam logic [RECIP_W-1:0] DSHOT_RECIP =
        RECIP_W'(((64'd1 << DSHOT_SHIFT) + 64'(DSHOT_SPAN) - 64'd1) / 64'(DSHOT_SPAN));
    localparam logic [RECIP_W-1:0] PWM_RECIP =
        RECIP_W'(((64'd1 << PWM_SHIFT) + 64'(PWM_DIV) - 64'd1) / 64'(PWM_DIV));

    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(FULL_SCALE);
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = LEVEL_W'(-FULL_SCALE);

    typedef enum logic [OP_W-1:0] {
        OP_SET         = 2'd0,
        OP_TICK        = 2'd1,
        OP_STOP        = 2'd2,
        OP_RESET_LEVEL = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIDIRECTIONAL = 3'd0,
        CFG_OUTPUT_MODE   = 3'd1,
        CFG_PULSE_MIN     = 3'd2,
        CFG_PULSE_MAX     = 3'd3,
        CFG_RISE_RATE     = 3'd4,
        CFG_FALL_RATE     = 3'd5,
        CFG_RISE_LIMIT_ON = 3'd6,
        CFG_FALL_LIMIT_ON = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic               bidirectional;
        logic               output_mode;
        logic [PULSE_W-1:0] pulse_min_us;
        logic [PULSE_W-1:0] pulse_max_us;
        logic [RATE_W-1:0]  rise_rate;
        logic [RATE_W-1:0]  fall_rate;
        logic               rise_limit_on;
        logic               fall_limit_on;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        bidirectional: 1'b0,
        output_mode:   1'b0,
        pulse_min_us:  PULSE_W'(1000),
        pulse_max_us:  PULSE_W'(2000),
        rise_rate:     RATE_W'(500),
        fall_rate:     RATE_W'(1000),
        rise_limit_on: 1'b1,
        fall_limit_on: 1'b1
    };

endpackage

/* design/tsl_if.sv */
// Channel interfaces: command items, result items and configuration writes.
// Each carries valid, ready and its payload. Depends on tsl_pkg.
interface tsl_item_if;
    logic                                valid;
    logic                                ready;
    logic [tsl_pkg::OP_W-1:0]            op;
    logic signed [tsl_pkg::LEVEL_W-1:0]  throttle_command;
    logic [tsl_pkg::MS_W-1:0]            elapsed_ms;

    modport source (output valid, output op, output throttle_command, output elapsed_ms,
                    input ready);
    modport sink   (input valid, input op, input throttle_command, input elapsed_ms,
                    output ready);
endinterface

interface tsl_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [tsl_pkg::LEVEL_W-1:0]  actual_throttle;
    logic [tsl_pkg::DRIVE_W-1:0]         drive_value;
    logic                                at_target;

    modport source (output valid, output actual_throttle, output drive_value,
                    output at_target, input ready);
    modport sink   (input valid, input actual_throttle, input drive_value,
                    input at_target, output ready);
endinterface

interface tsl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tsl_pkg::CFG_IDX_W-1:0]       index;
    logic [tsl_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/tsl_slew.sv */
// Command and actual throttle state with the set, tick, stop and reset-level update.
// One rate-times-time multiply, a compare and an add per item. Depends on tsl_pkg.
module tsl_slew (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  tsl_pkg::op_t                        op,
    input  logic signed [tsl_pkg::LEVEL_W-1:0]  command,
    input  logic [tsl_pkg::MS_W-1:0]            elapsed_ms,
    input  tsl_pkg::cfg_t                       cfg,
    output logic signed [tsl_pkg::LEVEL_W-1:0]  present_level,
    output logic signed [tsl_pkg::LEVEL_W-1:0]  target_level
);

    logic signed [tsl_pkg::LEVEL_W-1:0] present_level_reg, present_level_next;
    logic signed [tsl_pkg::LEVEL_W-1:0] target_level_reg, target_level_next;
    logic signed [tsl_pkg::LEVEL_W-1:0] lo_bound;
    logic signed [tsl_pkg::LEVEL_W-1:0] cmd_clamped;
    logic signed [tsl_pkg::LEVEL_W-1:0] ramped;
    logic [tsl_pkg::STEP_MS_W-1:0]      ms;
    logic signed [tsl_pkg::DIFF_W-1:0]  diff;
    logic [tsl_pkg::DIFF_W-1:0]         diff_mag;
    logic                               rising;
    logic                               limit_on;
    logic [tsl_pkg::RATE_W-1:0]         rate;
    logic [tsl_pkg::STEP_W-1:0]         step;

    always_comb
    begin
        lo_bound = cfg.bidirectional ? tsl_pkg::LEVEL_MIN : '0;
        priority if (command < lo_bound)
        begin
            cmd_clamped = lo_bound;
        end
        else if (command > tsl_pkg::LEVEL_MAX)
        begin
            cmd_clamped = tsl_pkg::LEVEL_MAX;
        end
        else
        begin
            cmd_clamped = command;
        end
    end

    // A gap longer than the limit counts as no time at all.
    assign ms = (elapsed_ms > tsl_pkg::MS_W'(tsl_pkg::ELAPSED_LIMIT)) ?
                '0 : elapsed_ms[tsl_pkg::STEP_MS_W-1:0];

    assign diff     = tsl_pkg::DIFF_W'(target_level_reg) - tsl_pkg::DIFF_W'(present_level_reg);
    assign rising   = !diff[tsl_pkg::DIFF_W-1] && (diff != '0);
    assign diff_mag = diff[tsl_pkg::DIFF_W-1] ? tsl_pkg::DIFF_W'(-diff) : tsl_pkg::DIFF_W'(diff);
    assign rate     = rising ? cfg.rise_rate : cfg.fall_rate;
    assign limit_on = rising ? cfg.rise_limit_on : cfg.fall_limit_on;
    assign step     = tsl_pkg::STEP_W'(rate) * tsl_pkg::STEP_W'(ms);

    // When the remaining distance is larger than the step, the step fits in the level width.
    always_comb
    begin
        if (!limit_on || (tsl_pkg::STEP_W'(diff_mag) <= step))
        begin
            ramped = target_level_reg;
        end
        else if (rising)
        begin
            ramped = present_level_reg + tsl_pkg::LEVEL_W'(step);
        end
        else
        begin
            ramped = present_level_reg - tsl_pkg::LEVEL_W'(step);
        end
    end

    always_comb
    begin
        present_level_next = present_level_reg;
        target_level_next  = target_level_reg;
        unique case (op)
            tsl_pkg::OP_SET:
            begin
                target_level_next = cmd_clamped;
                if (!cfg.rise_limit_on && !cfg.fall_limit_on)
                begin
                    present_level_next = cmd_clamped;
                end
            end
            tsl_pkg::OP_TICK:
            begin
                present_level_next = ramped;
            end
            tsl_pkg::OP_STOP:
            begin
                present_level_next = '0;
                target_level_next  = '0;
            end
            tsl_pkg::OP_RESET_LEVEL:
            begin
                present_level_next = '0;
            end
            default:
            begin
                present_level_next = present_level_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_level_reg <= '0;
            target_level_reg  <= '0;
        end
        else if (load)
        begin
            present_level_reg <= present_level_next;
            target_level_reg  <= target_level_next;
        end
    end

    assign present_level = present_level_reg;
    assign target_level  = target_level_reg;

endmodule

/* design/tsl_map.sv */
// Maps the actual throttle to a DSHOT code or a PWM pulse width in two registered
// stages: scale multiply, then exact division by reciprocal multiply. Depends on tsl_pkg.
module tsl_map (
    input  logic                                clk,
    input  logic                                advance,
    input  tsl_pkg::cfg_t                       cfg,
    input  logic signed [tsl_pkg::LEVEL_W-1:0]  level,
    input  logic                                at_target,
    output logic signed [tsl_pkg::LEVEL_W-1:0]  level_out,
    output logic                                at_target_out,
    output logic [tsl_pkg::DRIVE_W-1:0]         drive
);

    logic [tsl_pkg::LEVEL_W-1:0]        mag_full;
    logic [tsl_pkg::MAG_W-1:0]          mag;
    logic [tsl_pkg::MAG_W-1:0]          excess;
    logic                               above_pos;
    logic                               below_neg;
    logic                               at_full;
    logic [tsl_pkg::PULSE_W:0]          center_sum;
    logic [tsl_pkg::PULSE_W-1:0]        center;
    logic [tsl_pkg::PULSE_W-1:0]        half;
    logic [tsl_pkg::PULSE_W-1:0]        range;
    logic [tsl_pkg::MAG_W-1:0]          mul_a;
    logic [tsl_pkg::PULSE_W-1:0]        mul_b;
    logic [tsl_pkg::DRIVE_W-1:0]        base;
    logic                               subtract;
    logic                               pwm;

    logic [tsl_pkg::PROD_W-1:0]         c_prod_reg;
    logic [tsl_pkg::DRIVE_W-1:0]        c_base_reg;
    logic                               c_sub_reg;
    logic                               c_pwm_reg;
    logic signed [tsl_pkg::LEVEL_W-1:0] c_level_reg;
    logic                               c_eq_reg;

    logic [tsl_pkg::NUM_W-1:0]          numer;
    logic [tsl_pkg::RECIP_W-1:0]        recip;
    logic [tsl_pkg::QPROD_W-1:0]        qprod;
    logic [tsl_pkg::DRIVE_W-1:0]        quot;

    logic [tsl_pkg::DRIVE_W-1:0]        d_quot_reg;
    logic [tsl_pkg::DRIVE_W-1:0]        d_base_reg;
    logic                               d_sub_reg;
    logic signed [tsl_pkg::LEVEL_W-1:0] d_level_reg;
    logic                               d_eq_reg;

    // Magnitude saturates at full scale; levels are kept in range, so this is a guard.
    assign mag_full  = level[tsl_pkg::LEVEL_W-1] ? tsl_pkg::LEVEL_W'(-level)
                                                 : tsl_pkg::LEVEL_W'(level);
    assign mag       = (mag_full > tsl_pkg::LEVEL_W'(tsl_pkg::FULL_SCALE)) ?
                       tsl_pkg::MAG_W'(tsl_pkg::FULL_SCALE) : mag_full[tsl_pkg::MAG_W-1:0];
    assign excess    = mag - tsl_pkg::MAG_W'(tsl_pkg::DEADBAND);
    assign above_pos = level > tsl_pkg::LEVEL_W'(tsl_pkg::DEADBAND);
    assign below_neg = level < tsl_pkg::LEVEL_W'(-tsl_pkg::DEADBAND);
    assign at_full   = level >= tsl_pkg::LEVEL_MAX;

    assign center_sum = {1'b0, cfg.pulse_min_us} + {1'b0, cfg.pulse_max_us};
    assign center     = center_sum[tsl_pkg::PULSE_W:1];
    assign half       = center - cfg.pulse_min_us;
    assign range      = cfg.pulse_max_us - cfg.pulse_min_us;

    // Constant results go through the multiplier with a zero factor.
    always_comb
    begin
        mul_a    = excess;
        mul_b    = '0;
        base     = '0;
        subtract = 1'b0;
        pwm      = cfg.output_mode;
        if (!cfg.output_mode)
        begin
            if (!cfg.bidirectional)
            begin
                priority if (at_full)
                begin
                    base = tsl_pkg::DRIVE_W'(tsl_pkg::DSHOT_HIGH);
                end
                else if (above_pos)
                begin
                    base  = tsl_pkg::DRIVE_W'(tsl_pkg::DSHOT_LOW);
                    mul_b = tsl_pkg::PULSE_W'(tsl_pkg::DSHOT_UNI_K);
                end
                else
                begin
                    base = '0;
                end
            end
            else
            begin
                priority if (below_neg)
                begin
                    base  = tsl_pkg::DRIVE_W'(tsl_pkg::DSHOT_LOW);
                    mul_b = tsl_pkg::PULSE_W'(tsl_pkg::DSHOT_REV_K);
                end
                else if (above_pos)
                begin
                    base  = tsl_pkg::DRIVE_W'(tsl_pkg::DSHOT_FWD_LOW);
                    mul_b = tsl_pkg::PULSE_W'(tsl_pkg::DSHOT_FWD_K);
                end
                else
                begin
                    base = '0;
                end
            end
        end
        else
        begin
            mul_a = mag;
            if (!cfg.bidirectional)
            begin
                base = cfg.pulse_min_us;
                if (above_pos)
                begin
                    mul_b = range;
                end
            end
            else
            begin
                base     = center;
                mul_b    = half;
                subtract = level[tsl_pkg::LEVEL_W-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_prod_reg  <= tsl_pkg::PROD_W'(mul_a) * tsl_pkg::PROD_W'(mul_b);
            c_base_reg  <= base;
            c_sub_reg   <= subtract;
            c_pwm_reg   <= pwm;
            c_level_reg <= level;
            c_eq_reg    <= at_target;
        end
    end

    // PWM divides by full scale as a shift by 5 and then a division by 3125.
    assign numer = c_pwm_reg ? c_prod_reg[tsl_pkg::PWM_PRE_SHIFT +: tsl_pkg::NUM_W]
                             : c_prod_reg[tsl_pkg::NUM_W-1:0];
    assign recip = c_pwm_reg ? tsl_pkg::PWM_RECIP : tsl_pkg::DSHOT_RECIP;
    assign qprod = tsl_pkg::QPROD_W'(numer) * tsl_pkg::QPROD_W'(recip);
    assign quot  = c_pwm_reg ? tsl_pkg::DRIVE_W'(qprod >> tsl_pkg::PWM_SHIFT)
                             : tsl_pkg::DRIVE_W'(qprod >> tsl_pkg::DSHOT_SHIFT);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_quot_reg  <= quot;
            d_base_reg  <= c_base_reg;
            d_sub_reg   <= c_sub_reg;
            d_level_reg <= c_level_reg;
            d_eq_reg    <= c_eq_reg;
        end
    end

    // Pulse arithmetic wraps modulo 2**16.
    assign drive         = d_sub_reg ? (d_base_reg - d_quot_reg) : (d_base_reg + d_quot_reg);
    assign level_out     = d_level_reg;
    assign at_target_out = d_eq_reg;

endmodule

/* design/throttle_slew_limiter_with_dshot_pwm_map.sv */
// Top level of the throttle slew limiter with DSHOT/PWM drive mapping.
// Depends on tsl_pkg, the interfaces in tsl_if, tsl_slew and tsl_map.
//
// Usage:
//   item   - command transactions: op (set, tick, stop, reset level), throttle_command
//            for set, elapsed_ms for tick.
//   result - one transaction per item: actual_throttle, drive_value (DSHOT code or PWM
//            microseconds per output_mode) and at_target.
//   cfg    - register writes by index; always ready. Write only while no item is in flight.
// Timing:
//   One item is accepted per cycle unless a result waits unaccepted. Its result passes
//   through the input register, the state update, the scale multiply, the reciprocal
//   multiply and the result register. The state update with its rate-times-time multiply
//   must finish before the next item, since the next item reads the updated levels.
// Stalls:
//   The whole pipeline advances together; while a result waits unaccepted the
//   pipeline holds and item.ready is low. Bubbles in the pipeline move along with it.
// Reset:
//   rst_n clears both levels to zero, empties the pipeline and loads the register
//   defaults (1000/2000 us pulses, rates 500 and 1000 %/s, both ramps on).
module throttle_slew_limiter_with_dshot_pwm_map (
    input  logic                 clk,
    input  logic                 rst_n,
    tsl_item_if.sink             item,
    tsl_result_if.source         result,
    tsl_cfg_if.sink              cfg
);

    tsl_pkg::cfg_t                      cfg_reg, cfg_next;

    logic                               advance;
    logic                               a_valid_reg;
    logic                               b_valid_reg;
    logic                               c_valid_reg;
    logic                               d_valid_reg;
    logic                               result_valid_reg;

    tsl_pkg::op_t                       a_op_reg;
    logic signed [tsl_pkg::LEVEL_W-1:0] a_cmd_reg;
    logic [tsl_pkg::MS_W-1:0]           a_ms_reg;

    logic signed [tsl_pkg::LEVEL_W-1:0] present_level;
    logic signed [tsl_pkg::LEVEL_W-1:0] target_level;
    logic signed [tsl_pkg::LEVEL_W-1:0] map_level;
    logic                               map_at_target;
    logic [tsl_pkg::DRIVE_W-1:0]        map_drive;

    logic signed [tsl_pkg::LEVEL_W-1:0] result_level_reg;
    logic [tsl_pkg::DRIVE_W-1:0]        result_drive_reg;
    logic                               result_eq_reg;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (tsl_pkg::cfg_idx_t'(cfg.index))
                tsl_pkg::CFG_BIDIRECTIONAL: cfg_next.bidirectional = cfg.data[0];
                tsl_pkg::CFG_OUTPUT_MODE:   cfg_next.output_mode   = cfg.data[0];
                tsl_pkg::CFG_PULSE_MIN:     cfg_next.pulse_min_us  = cfg.data;
                tsl_pkg::CFG_PULSE_MAX:     cfg_next.pulse_max_us  = cfg.data;
                tsl_pkg::CFG_RISE_RATE:     cfg_next.rise_rate     = cfg.data;
                tsl_pkg::CFG_FALL_RATE:     cfg_next.fall_rate     = cfg.data;
                tsl_pkg::CFG_RISE_LIMIT_ON: cfg_next.rise_limit_on = cfg.data[0];
                tsl_pkg::CFG_FALL_LIMIT_ON: cfg_next.fall_limit_on = cfg.data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tsl_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg.ready = 1'b1;

    // Pipeline control: everything moves unless a finished result is being held.
    assign advance    = !result_valid_reg || result.ready;
    assign item.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            d_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg      <= item.valid;
            b_valid_reg      <= a_valid_reg;
            c_valid_reg      <= b_valid_reg;
            d_valid_reg      <= c_valid_reg;
            result_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_op_reg  <= tsl_pkg::op_t'(item.op);
            a_cmd_reg <= item.throttle_command;
            a_ms_reg  <= item.elapsed_ms;
        end
    end

    tsl_slew u_slew (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && a_valid_reg),
        .op            (a_op_reg),
        .command       (a_cmd_reg),
        .elapsed_ms    (a_ms_reg),
        .cfg           (cfg_reg),
        .present_level (present_level),
        .target_level  (target_level)
    );

    // The level registers hold the values of the item now in the second stage.
    tsl_map u_map (
        .clk           (clk),
        .advance       (advance),
        .cfg           (cfg_reg),
        .level         (present_level),
        .at_target     (present_level == target_level),
        .level_out     (map_level),
        .at_target_out (map_at_target),
        .drive         (map_drive)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_level_reg <= map_level;
            result_drive_reg <= map_drive;
            result_eq_reg    <= map_at_target;
        end
    end

    assign result.valid           = result_valid_reg;
    assign result.actual_throttle = result_level_reg;
    assign result.drive_value     = result_drive_reg;
    assign result.at_target       = result_eq_reg;

`ifndef NO_ASSERTIONS
    // The command never leaves full scale, since set clamps it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (target_level >= tsl_pkg::LEVEL_MIN) && (target_level <= tsl_pkg::LEVEL_MAX))
        else $error("command level outside full scale");

    // A stop clears both levels.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && a_valid_reg && (a_op_reg == tsl_pkg::OP_STOP))
        |=> (present_level == '0) && (target_level == '0))
        else $error("stop did not clear the levels");

    // A tick moves the actual level toward the command without passing it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && a_valid_reg && (a_op_reg == tsl_pkg::OP_TICK))
        |=> (($past(target_level) >= $past(present_level)) ?
             ((present_level <= target_level) && (present_level >= $past(present_level))) :
             ((present_level >= target_level) && (present_level <= $past(present_level)))))
        else $error("tick overshot the command");
`endif

endmodule
